// ----- hw/rtl/wsdf_pkg.sv -----
// ----------------------------------------------------------------------------
// wsdf_pkg
// Types, codes and constants shared by the WebSocket frame deframer files.
// ----------------------------------------------------------------------------
`default_nettype none

package wsdf_pkg;

	localparam int unsigned LENGTH_WIDTH_DEF = 64;
	localparam int unsigned PLEN_W           = 64;
	localparam int unsigned CFG_IDX_W        = 1;
	localparam int unsigned CFG_DATA_W       = 1;

	// 7-bit length field codes
	localparam logic [6:0] CTRL_MAX_LEN = 7'd125;
	localparam logic [6:0] LEN_IS_16    = 7'd126;
	localparam logic [6:0] LEN_IS_64    = 7'd127;

	// opcodes
	localparam logic [3:0] OP_CONT   = 4'd0;
	localparam logic [3:0] OP_TEXT   = 4'd1;
	localparam logic [3:0] OP_BINARY = 4'd2;
	localparam logic [3:0] OP_CLOSE  = 4'd8;
	localparam logic [3:0] OP_PING   = 4'd9;
	localparam logic [3:0] OP_PONG   = 4'd10;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SERVER_ROLE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSION  = 1'd1;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ERR_NONE          = 4'd0,
		ERR_UNMASKED      = 4'd1,
		ERR_CONT_EXPECTED = 4'd2,
		ERR_RSV_DATA      = 4'd3,
		ERR_RSV_CONT      = 4'd4,
		ERR_DANGLING_CONT = 4'd5,
		ERR_RSV_CTRL      = 4'd6,
		ERR_CTRL_LEN      = 4'd7,
		ERR_CTRL_FRAG     = 4'd8,
		ERR_BAD_OPCODE    = 4'd9
	} err_t;

	typedef enum logic [1:0] {
		LEN_MODE_7  = 2'd0,
		LEN_MODE_16 = 2'd1,
		LEN_MODE_64 = 2'd2
	} len_mode_t;

endpackage

`default_nettype wire

// ----- hw/rtl/wsdf_byte_if.sv -----
// ----------------------------------------------------------------------------
// wsdf_byte_if
// Valid/ready channel carrying one raw stream byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsdf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink   (input valid, input stream_byte, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/wsdf_rec_if.sv -----
// ----------------------------------------------------------------------------
// wsdf_rec_if
// Valid/ready channel carrying one deframer record per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsdf_rec_if;
	import wsdf_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        record_kind;
	logic [3:0]        frame_opcode;
	logic [3:0]        message_opcode;
	logic              frame_fin;
	logic              compressed_flag;
	logic              was_masked;
	logic [PLEN_W-1:0] payload_length;
	logic [7:0]        payload_byte;
	logic              frame_last;
	logic [3:0]        error_code;

	modport source (
		output valid, output record_kind, output frame_opcode, output message_opcode,
		output frame_fin, output compressed_flag, output was_masked,
		output payload_length, output payload_byte, output frame_last,
		output error_code, input ready
	);
	modport sink (
		input valid, input record_kind, input frame_opcode, input message_opcode,
		input frame_fin, input compressed_flag, input was_masked,
		input payload_length, input payload_byte, input frame_last,
		input error_code, output ready
	);
endinterface

`default_nettype wire

// ----- hw/rtl/websocket_frame_deframer.sv -----
// Latency: a record is valid in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; a new byte is taken whenever the record register
// is empty or being drained, so the single record register sets the rate.
// Reset (arst_n low, asynchronous): parser idle at the first header byte, no
// message in progress, error cleared, server_role = 1, compression_enabled = 0.
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses WebSocket frame headers, unmasks payload bytes and flags protocol faults.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer #(
	parameter int unsigned LENGTH_WIDTH = wsdf_pkg::LENGTH_WIDTH_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire [wsdf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire [wsdf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	wsdf_byte_if.sink                       stream,
	wsdf_rec_if.source                      records
);
	import wsdf_pkg::*;

	// configuration
	logic server_role_q;
	logic compression_q;

	// parser state
	logic [3:0]              hdr_idx_q,    hdr_idx_n;
	logic                    in_payload_q, in_payload_n;
	len_mode_t               len_mode_q,   len_mode_n;
	logic [7:0]              hdr_b0_q,     hdr_b0_n;
	logic [LENGTH_WIDTH-1:0] len_acc_q,    len_acc_n;
	logic [31:0]             mask_key_q,   mask_key_n;
	logic [1:0]              key_pos_q,    key_pos_n;
	logic [LENGTH_WIDTH-1:0] bytes_left_q, bytes_left_n;
	logic [3:0]              msg_op_q,     msg_op_n;
	logic                    msg_fin_q,    msg_fin_n;
	logic                    msg_rsv1_q,   msg_rsv1_n;
	logic                    err_q,        err_n;
	logic                    masked_q,     masked_n;

	// record register
	logic              rec_valid_q;
	kind_t             rec_kind_q;
	logic [PLEN_W-1:0] rec_plen_q;
	logic [7:0]        rec_pbyte_q;
	logic              rec_last_q;
	err_t              rec_err_q;
	logic [3:0]        rec_fop_q;
	logic [3:0]        rec_mop_q;
	logic              rec_fin_q;
	logic              rec_rsv1_q;
	logic              rec_masked_q;

	// combinational result
	logic              emit_c;
	kind_t             kind_c;
	logic [PLEN_W-1:0] plen_c;
	logic [7:0]        pbyte_c;
	logic              last_c;
	err_t              code_c;
	logic              finish_c;

	logic       accept;
	logic [7:0] b;
	logic [7:0] key_byte;
	logic [6:0] len7;
	logic [2:0] rsv;
	logic [3:0] op;
	logic [3:0] hdr_end;
	logic [3:0] hdr_total;
	logic [3:0] hdr_idx_inc;

	assign stream.ready = !rec_valid_q || records.ready;
	assign accept       = stream.valid && stream.ready;
	assign b            = stream.stream_byte;
	assign len7         = b[6:0];
	assign op           = hdr_b0_q[3:0];
	assign rsv          = hdr_b0_q[6:4];
	assign key_byte     = 8'(mask_key_q >> {~key_pos_q, 3'b000});
	assign hdr_idx_inc  = hdr_idx_q + 4'd1;

	always_comb begin
		case (len_mode_q)
			LEN_MODE_16: hdr_end = 4'd4;
			LEN_MODE_64: hdr_end = 4'd10;
			default:     hdr_end = 4'd2;
		endcase
		hdr_total = hdr_end + (masked_q ? 4'd4 : 4'd0);
	end

	always_comb begin
		hdr_idx_n    = hdr_idx_q;
		in_payload_n = in_payload_q;
		len_mode_n   = len_mode_q;
		hdr_b0_n     = hdr_b0_q;
		len_acc_n    = len_acc_q;
		mask_key_n   = mask_key_q;
		key_pos_n    = key_pos_q;
		bytes_left_n = bytes_left_q;
		msg_op_n     = msg_op_q;
		msg_fin_n    = msg_fin_q;
		msg_rsv1_n   = msg_rsv1_q;
		err_n        = err_q;
		masked_n     = masked_q;
		emit_c       = 1'b0;
		kind_c       = KIND_HEADER;
		plen_c       = PLEN_W'(len_acc_q);
		pbyte_c      = 8'd0;
		last_c       = 1'b0;
		code_c       = ERR_NONE;
		finish_c     = 1'b0;

		if (!err_q) begin
			if (in_payload_q) begin
				key_pos_n    = key_pos_q + 2'd1;
				bytes_left_n = bytes_left_q - LENGTH_WIDTH'(1);
				last_c       = (bytes_left_n == '0);
				if (last_c)
					in_payload_n = 1'b0;
				emit_c  = 1'b1;
				kind_c  = KIND_PAYLOAD;
				pbyte_c = b ^ key_byte;
			end else if (hdr_idx_q == 4'd0) begin
				if (msg_fin_q) begin
					msg_fin_n  = 1'b0;
					msg_rsv1_n = 1'b0;
					msg_op_n   = OP_CONT;
				end
				hdr_b0_n   = b;
				masked_n   = 1'b0;
				len_acc_n  = '0;
				mask_key_n = '0;
				len_mode_n = LEN_MODE_7;
				hdr_idx_n  = 4'd1;
			end else if (hdr_idx_q == 4'd1) begin
				masked_n = b[7];
				if (server_role_q && !b[7]) begin
					code_c = ERR_UNMASKED;
				end else begin
					case (op)
						OP_TEXT, OP_BINARY: begin
							if (msg_op_q != OP_CONT)
								code_c = ERR_CONT_EXPECTED;
							else if ((compression_q ? {1'b0, rsv[1:0]} : rsv) != 3'd0)
								code_c = ERR_RSV_DATA;
							else begin
								msg_fin_n  = hdr_b0_q[7];
								msg_rsv1_n = hdr_b0_q[6];
								msg_op_n   = op;
							end
						end
						OP_CONT: begin
							if (rsv != 3'd0)
								code_c = ERR_RSV_CONT;
							else if (msg_op_q == OP_CONT)
								code_c = ERR_DANGLING_CONT;
							else if (hdr_b0_q[7])
								msg_fin_n = 1'b1;
						end
						OP_CLOSE, OP_PING, OP_PONG: begin
							if (rsv != 3'd0)
								code_c = ERR_RSV_CTRL;
							else if (len7 > CTRL_MAX_LEN)
								code_c = ERR_CTRL_LEN;
							else if (!hdr_b0_q[7])
								code_c = ERR_CTRL_FRAG;
						end
						default: code_c = ERR_BAD_OPCODE;
					endcase
				end
				if (code_c != ERR_NONE) begin
					err_n  = 1'b1;
					emit_c = 1'b1;
					kind_c = KIND_ERROR;
					plen_c = '0;
				end else begin
					if (len7 == LEN_IS_16)
						len_mode_n = LEN_MODE_16;
					else if (len7 == LEN_IS_64)
						len_mode_n = LEN_MODE_64;
					else begin
						len_mode_n = LEN_MODE_7;
						len_acc_n  = LENGTH_WIDTH'(len7);
					end
					hdr_idx_n = 4'd2;
					finish_c  = (len7 < LEN_IS_16) && !b[7];
				end
			end else begin
				if (hdr_idx_q < hdr_end)
					len_acc_n = {len_acc_q[LENGTH_WIDTH-9:0], b};
				else
					mask_key_n = {mask_key_q[23:0], b};
				hdr_idx_n = hdr_idx_inc;
				finish_c  = (hdr_idx_inc >= hdr_total);
			end

			if (finish_c) begin
				bytes_left_n = len_acc_n;
				hdr_idx_n    = 4'd0;
				key_pos_n    = 2'd0;
				in_payload_n = (len_acc_n != '0);
				emit_c       = 1'b1;
				kind_c       = KIND_HEADER;
				plen_c       = PLEN_W'(len_acc_n);
				last_c       = (len_acc_n == '0);
			end
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_role_q <= 1'b1;
			compression_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SERVER_ROLE: server_role_q <= cfg_wdata[0];
				CFG_COMPRESSION: compression_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_idx_q    <= 4'd0;
			in_payload_q <= 1'b0;
			len_mode_q   <= LEN_MODE_7;
			hdr_b0_q     <= 8'd0;
			len_acc_q    <= '0;
			mask_key_q   <= '0;
			key_pos_q    <= 2'd0;
			bytes_left_q <= '0;
			msg_op_q     <= OP_CONT;
			msg_fin_q    <= 1'b0;
			msg_rsv1_q   <= 1'b0;
			err_q        <= 1'b0;
			masked_q     <= 1'b0;
		end else if (accept) begin
			hdr_idx_q    <= hdr_idx_n;
			in_payload_q <= in_payload_n;
			len_mode_q   <= len_mode_n;
			hdr_b0_q     <= hdr_b0_n;
			len_acc_q    <= len_acc_n;
			mask_key_q   <= mask_key_n;
			key_pos_q    <= key_pos_n;
			bytes_left_q <= bytes_left_n;
			msg_op_q     <= msg_op_n;
			msg_fin_q    <= msg_fin_n;
			msg_rsv1_q   <= msg_rsv1_n;
			err_q        <= err_n;
			masked_q     <= masked_n;
		end
	end

	// record register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
		end else if (accept) begin
			rec_valid_q <= emit_c;
		end else if (records.ready) begin
			rec_valid_q <= 1'b0;
		end
	end

	// record fields reflect state as it stands after the byte
	always_ff @(posedge clk) begin
		if (accept && emit_c) begin
			rec_kind_q   <= kind_c;
			rec_plen_q   <= plen_c;
			rec_pbyte_q  <= pbyte_c;
			rec_last_q   <= last_c;
			rec_err_q    <= code_c;
			rec_fop_q    <= hdr_b0_n[3:0];
			rec_mop_q    <= msg_op_n;
			rec_fin_q    <= hdr_b0_n[7];
			rec_rsv1_q   <= msg_rsv1_n;
			rec_masked_q <= masked_n;
		end
	end

	assign records.valid           = rec_valid_q;
	assign records.record_kind     = rec_kind_q;
	assign records.frame_opcode    = rec_fop_q;
	assign records.message_opcode  = rec_mop_q;
	assign records.frame_fin       = rec_fin_q;
	assign records.compressed_flag = rec_rsv1_q;
	assign records.was_masked      = rec_masked_q;
	assign records.payload_length  = rec_plen_q;
	assign records.payload_byte    = rec_pbyte_q;
	assign records.frame_last      = rec_last_q;
	assign records.error_code      = rec_err_q;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives WebSocket frame byte streams into the deframer under random idling
// on both channels and compares every header, payload and error record
// against an in-bench predictor of the parser state.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import wsdf_pkg::*;

	localparam int CLK_PERIOD     = 4;
	localparam int RESET_CYCLES   = 10;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_OFF       = 300;
	localparam int SETTLE_CYCLES  = 4;
	localparam int PHASE_BYTES    = 215;
	localparam logic [63:0] LEN_MASK = {64{1'b1}} >> (64 - LENGTH_WIDTH_DEF);

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  frame_op;
		logic [3:0]  msg_op;
		logic        fin;
		logic        compressed;
		logic        masked;
		logic [63:0] plen;
		logic [7:0]  data;
		logic        last;
		err_t        err;
	} record_t;

	function automatic string describe(record_t r);
		return $sformatf({"kind=%0d fop=%0d mop=%0d fin=%0b cmp=%0b msk=%0b ",
			"len=%0h byte=%0h last=%0b err=%0d"}, r.kind, r.frame_op, r.msg_op,
			r.fin, r.compressed, r.masked, r.plen, r.data, r.last, r.err);
	endfunction

	// Parser state mirror plus the queue of records still owed by the block
	class record_scoreboard;
		bit          server_role    = 1'b1;
		bit          compression_on = 1'b0;
		logic [3:0]  hdr_idx        = '0;
		bit          in_payload;
		len_mode_t   len_mode       = LEN_MODE_7;
		logic [7:0]  first_byte     = '0;
		logic [63:0] len_acc        = '0;
		logic [31:0] key            = '0;
		logic [1:0]  key_pos        = '0;
		logic [63:0] bytes_left     = '0;
		logic [3:0]  msg_op         = '0;
		bit          msg_fin;
		bit          msg_rsv1;
		bit          faulted;
		bit          masked;
		record_t     pending_records[$];
		int          failures;

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == CFG_SERVER_ROLE)
				server_role = val[0];
			else if (idx == CFG_COMPRESSION)
				compression_on = val[0];
		endfunction

		function void queue_record(kind_t kind, logic [63:0] plen, logic [7:0] data,
				bit last, err_t code);
			record_t r;
			r.kind       = kind;
			r.frame_op   = first_byte[3:0];
			r.msg_op     = msg_op;
			r.fin        = first_byte[7];
			r.compressed = msg_rsv1;
			r.masked     = masked;
			r.plen       = plen;
			r.data       = data;
			r.last       = last;
			r.err        = code;
			pending_records.push_back(r);
		endfunction

		function void close_header();
			bytes_left = len_acc;
			hdr_idx    = '0;
			key_pos    = '0;
			in_payload = (bytes_left != 0);
			queue_record(KIND_HEADER, len_acc, 8'h00, bytes_left == 0, ERR_NONE);
		endfunction

		// Masking first, then the checks of the opcode class; data frames open
		// or extend the message only when they pass.
		function err_t frame_fault(logic [6:0] len7);
			logic [3:0] op;
			logic [2:0] rsv;
			op  = first_byte[3:0];
			rsv = first_byte[6:4];
			if (server_role && !masked)
				return ERR_UNMASKED;
			case (op)
				OP_TEXT, OP_BINARY: begin
					if (msg_op != '0)
						return ERR_CONT_EXPECTED;
					if (compression_on)
						rsv[2] = 1'b0;
					if (rsv != '0)
						return ERR_RSV_DATA;
					msg_fin  = first_byte[7];
					msg_rsv1 = first_byte[6];
					msg_op   = op;
					return ERR_NONE;
				end
				OP_CONT: begin
					if (rsv != '0)
						return ERR_RSV_CONT;
					if (msg_op == '0)
						return ERR_DANGLING_CONT;
					if (first_byte[7])
						msg_fin = 1'b1;
					return ERR_NONE;
				end
				OP_CLOSE, OP_PING, OP_PONG: begin
					if (rsv != '0)
						return ERR_RSV_CTRL;
					if (len7 > CTRL_MAX_LEN)
						return ERR_CTRL_LEN;
					if (!first_byte[7])
						return ERR_CTRL_FRAG;
					return ERR_NONE;
				end
				default: return ERR_BAD_OPCODE;
			endcase
		endfunction

		function void take_byte(logic [7:0] b);
			logic [7:0] kb;
			logic [6:0] len7;
			err_t       code;
			int         ext;
			int         total;
			if (faulted)
				return;
			if (in_payload) begin
				kb = key[8*(3-key_pos) +: 8];
				key_pos++;
				bytes_left--;
				if (bytes_left == 0)
					in_payload = 1'b0;
				queue_record(KIND_PAYLOAD, len_acc, b ^ kb, bytes_left == 0, ERR_NONE);
				return;
			end
			if (hdr_idx == 0) begin
				if (msg_fin) begin
					msg_fin  = 1'b0;
					msg_rsv1 = 1'b0;
					msg_op   = '0;
				end
				first_byte = b;
				masked     = 1'b0;
				len_acc    = '0;
				key        = '0;
				len_mode   = LEN_MODE_7;
				hdr_idx    = 4'd1;
				return;
			end
			if (hdr_idx == 1) begin
				len7   = b[6:0];
				masked = b[7];
				code   = frame_fault(len7);
				if (code != ERR_NONE) begin
					faulted = 1'b1;
					queue_record(KIND_ERROR, '0, 8'h00, 1'b0, code);
					return;
				end
				if (len7 == LEN_IS_16)
					len_mode = LEN_MODE_16;
				else if (len7 == LEN_IS_64)
					len_mode = LEN_MODE_64;
				else begin
					len_mode = LEN_MODE_7;
					len_acc  = 64'(len7);
				end
				hdr_idx = 4'd2;
				if (len_mode == LEN_MODE_7 && !masked)
					close_header();
				return;
			end
			ext   = (len_mode == LEN_MODE_16) ? 2 : ((len_mode == LEN_MODE_64) ? 8 : 0);
			total = 2 + ext + (masked ? 4 : 0);
			if (hdr_idx < 2 + ext)
				len_acc = {len_acc[55:0], b} & LEN_MASK;
			else
				key = {key[23:0], b};
			hdr_idx++;
			if (hdr_idx >= total)
				close_header();
		endfunction

		function void check_record(record_t got);
			record_t want;
			if (pending_records.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected record: %s", describe(got));
				return;
			end
			want = pending_records.pop_front();
			if (got.kind !== want.kind || got.frame_op !== want.frame_op ||
					got.msg_op !== want.msg_op || got.fin !== want.fin ||
					got.compressed !== want.compressed || got.masked !== want.masked ||
					got.plen !== want.plen || got.data !== want.data ||
					got.last !== want.last || got.err !== want.err) begin
				failures++;
				if (failures <= 10) begin
					$display("record mismatch at %0t", $realtime);
					$display("  expected %s", describe(want));
					$display("  actual   %s", describe(got));
				end
			end
		endfunction
	endclass

	logic                  clk    = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	wsdf_byte_if stream_ch ();
	wsdf_rec_if  rec_ch ();

	websocket_frame_deframer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.stream    (stream_ch),
		.records   (rec_ch)
	);

	record_scoreboard board;

	bit hold_req;
	int send_quiet_left;
	int recv_quiet_left;
	int bytes_sent;
	bit server_on = 1'b1;
	bit comp_on;
	bit msg_open;

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic push_byte(input logic [7:0] b);
		int gap;
		if (send_quiet_left > 0) begin
			gap = 0;
			send_quiet_left--;
		end else begin
			gap = $urandom_range(0, 15);
			if ($urandom_range(0, 99) < 3)
				send_quiet_left = $urandom_range(20, 60);
		end
		@(negedge clk);
		if (gap > 0) begin
			stream_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		stream_ch.valid       <= 1'b1;
		stream_ch.stream_byte <= b;
		do @(posedge clk); while (!stream_ch.ready);
		board.take_byte(b);
		bytes_sent++;
	endtask

	task automatic set_config(input bit server, input bit comp);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SERVER_ROLE;
		cfg_wdata <= server;
		@(negedge clk);
		board.set_reg(CFG_SERVER_ROLE, server);
		cfg_index <= CFG_COMPRESSION;
		cfg_wdata <= comp;
		@(negedge clk);
		board.set_reg(CFG_COMPRESSION, comp);
		cfg_we    <= 1'b0;
		server_on = server;
		comp_on   = comp;
	endtask

	// Stop offering bytes and wait out every record still owed, plus the
	// pipeline latency in case the last bytes were header bytes.
	task automatic drain_records();
		@(negedge clk);
		stream_ch.valid <= 1'b0;
		while (board.pending_records.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_header(input logic [3:0] op, input logic fin, input logic [2:0] rsv,
			input logic masked_bit, input len_mode_t mode, input logic [63:0] length,
			input logic [31:0] mkey);
		logic [6:0] len7;
		int ext;
		case (mode)
			LEN_MODE_16: begin
				len7 = LEN_IS_16;
				ext  = 2;
			end
			LEN_MODE_64: begin
				len7 = LEN_IS_64;
				ext  = 8;
			end
			default: begin
				len7 = length[6:0];
				ext  = 0;
			end
		endcase
		push_byte({fin, rsv, op});
		push_byte({masked_bit, len7});
		for (int i = ext - 1; i >= 0; i--)
			push_byte(length[8*i +: 8]);
		if (masked_bit)
			for (int i = 3; i >= 0; i--)
				push_byte(mkey[8*i +: 8]);
		if (op == OP_TEXT || op == OP_BINARY)
			msg_open = !fin;
		else if (op == OP_CONT && fin)
			msg_open = 1'b0;
	endtask

	task automatic send_frame(input logic [3:0] op, input logic fin, input logic [2:0] rsv,
			input logic masked_bit, input len_mode_t mode, input logic [63:0] length,
			input logic [31:0] mkey);
		send_header(op, fin, rsv, masked_bit, mode, length, mkey);
		for (int i = 0; i < length; i++)
			push_byte(8'($urandom_range(0, 255)));
	endtask

	function automatic logic [3:0] ctrl_op();
		case ($urandom_range(0, 2))
			0: return OP_CLOSE;
			1: return OP_PING;
			default: return OP_PONG;
		endcase
	endfunction

	// Well-formed frame that keeps the message order legal
	task automatic random_frame();
		logic [3:0]  op;
		logic        fin;
		logic [2:0]  rsv;
		len_mode_t   mode;
		logic [63:0] length;
		int          pick;
		rsv  = 3'b000;
		mode = LEN_MODE_7;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < 15) begin
			op     = ctrl_op();
			fin    = 1'b1;
			length = (pick < 10) ? 64'(CTRL_MAX_LEN) : 64'($urandom_range(0, 12));
		end else begin
			fin = ($urandom_range(0, 9) < 6);
			if (msg_open)
				op = OP_CONT;
			else begin
				op = $urandom_range(0, 1) ? OP_TEXT : OP_BINARY;
				if (comp_on)
					rsv[2] = 1'($urandom_range(0, 1));
			end
			if (pick < 75)
				length = 64'($urandom_range(0, 12));
			else if (pick < 80)
				length = 64'($urandom_range(100, 125));
			else if (pick < 90) begin
				mode   = LEN_MODE_16;
				length = 64'($urandom_range(0, 160));
			end else begin
				mode   = LEN_MODE_64;
				length = 64'($urandom_range(0, 24));
			end
		end
		send_frame(op, fin, rsv, server_on ? 1'b1 : 1'($urandom_range(0, 1)), mode, length,
			$urandom());
	endtask

	// Closing scenario: either one protocol fault (which latches until reset)
	// or a 64-bit length with its top bit set that never ends.
	task automatic send_closing_case();
		err_t       fault;
		logic [3:0] op;
		logic [2:0] rsv;
		int         pick;
		fault = err_t'($urandom_range(0, 9));
		set_config((fault == ERR_UNMASKED) ? 1'b1 : 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
		case (fault)
			ERR_NONE:
				send_header(msg_open ? OP_CONT : OP_BINARY, 1'b1, 3'b000, 1'b1, LEN_MODE_64,
					$urandom_range(0, 1) ? '1 : {1'b1, 31'($urandom()), 32'($urandom())},
					$urandom());
			ERR_UNMASKED:
				send_header(msg_open ? OP_CONT : OP_TEXT, 1'($urandom_range(0, 1)), 3'b000,
					1'b0, LEN_MODE_7, 64'($urandom_range(0, 125)), '0);
			ERR_CONT_EXPECTED: begin
				if (!msg_open)
					send_frame(OP_TEXT, 1'b0, 3'b000, 1'b1, LEN_MODE_7, 64'd3, $urandom());
				send_header($urandom_range(0, 1) ? OP_TEXT : OP_BINARY,
					1'($urandom_range(0, 1)), 3'b000, 1'b1, LEN_MODE_7, 64'd5, $urandom());
			end
			ERR_RSV_DATA: begin
				if (msg_open)
					send_frame(OP_CONT, 1'b1, 3'b000, 1'b1, LEN_MODE_7, 64'd2, $urandom());
				rsv = comp_on ? {1'($urandom_range(0, 1)), 2'($urandom_range(1, 3))}
					: 3'($urandom_range(1, 7));
				send_header($urandom_range(0, 1) ? OP_TEXT : OP_BINARY,
					1'($urandom_range(0, 1)), rsv, 1'b1, LEN_MODE_7, 64'd4, $urandom());
			end
			ERR_RSV_CONT:
				send_header(OP_CONT, 1'($urandom_range(0, 1)), 3'($urandom_range(1, 7)), 1'b1,
					LEN_MODE_7, 64'd4, $urandom());
			ERR_DANGLING_CONT: begin
				if (msg_open)
					send_frame(OP_CONT, 1'b1, 3'b000, 1'b1, LEN_MODE_7, 64'd2, $urandom());
				send_header(OP_CONT, 1'($urandom_range(0, 1)), 3'b000, 1'b1, LEN_MODE_7,
					64'd4, $urandom());
			end
			ERR_RSV_CTRL:
				send_header(ctrl_op(), 1'b1, 3'($urandom_range(1, 7)), 1'b1, LEN_MODE_7,
					64'd4, $urandom());
			ERR_CTRL_LEN:
				send_header(ctrl_op(), 1'($urandom_range(0, 1)), 3'b000, 1'b1,
					$urandom_range(0, 1) ? LEN_MODE_16 : LEN_MODE_64,
					64'($urandom_range(0, 200)), $urandom());
			ERR_CTRL_FRAG:
				send_header(ctrl_op(), 1'b0, 3'b000, 1'b1, LEN_MODE_7,
					64'($urandom_range(0, 125)), $urandom());
			default: begin
				pick = $urandom_range(0, 9);
				op   = (pick < 5) ? 4'(3 + pick) : 4'(6 + pick);
				send_header(op, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), 1'b1,
					LEN_MODE_7, 64'd4, $urandom());
			end
		endcase
		// bytes after a fault must be swallowed without a record
		repeat (40)
			push_byte(8'($urandom_range(0, 255)));
	endtask

	initial begin
		record_t got;
		int      stall;
		rec_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				stall    = HOLD_OFF;
			end else if (recv_quiet_left > 0) begin
				stall = 0;
				recv_quiet_left--;
			end else begin
				stall = $urandom_range(0, 15);
				if ($urandom_range(0, 99) < 3)
					recv_quiet_left = $urandom_range(20, 60);
			end
			@(negedge clk);
			if (stall > 0) begin
				rec_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rec_ch.ready <= 1'b1;
			do @(posedge clk); while (!rec_ch.valid);
			got.kind       = kind_t'(rec_ch.record_kind);
			got.frame_op   = rec_ch.frame_opcode;
			got.msg_op     = rec_ch.message_opcode;
			got.fin        = rec_ch.frame_fin;
			got.compressed = rec_ch.compressed_flag;
			got.masked     = rec_ch.was_masked;
			got.plen       = rec_ch.payload_length;
			got.data       = rec_ch.payload_byte;
			got.last       = rec_ch.frame_last;
			got.err        = err_t'(rec_ch.error_code);
			board.check_record(got);
		end
	end

	initial begin
		int idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((stream_ch.valid && stream_ch.ready) || (rec_ch.valid && rec_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int phase_end;
		stream_ch.valid       = 1'b0;
		stream_ch.stream_byte = '0;
		cfg_we                = 1'b0;
		cfg_index             = '0;
		cfg_wdata             = '0;
		board = new();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_config(1'b1, 1'b0);
		// zero-length first fragment, a ping in between, then a 16-bit-length
		// final continuation
		send_frame(OP_TEXT, 1'b0, 3'b000, 1'b1, LEN_MODE_7, 64'd0, 32'hFFFF_FFFF);
		send_frame(OP_PING, 1'b1, 3'b000, 1'b1, LEN_MODE_7, 64'd1, 32'h0000_0000);
		send_frame(OP_CONT, 1'b1, 3'b000, 1'b1, LEN_MODE_16, 64'd2, 32'h8001_7FFE);
		drain_records();

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: set_config(1'b1, 1'b1);
				1: set_config(1'b0, 1'b0);
				2: set_config(1'b0, 1'b1);
				3: set_config(1'b1, 1'b0);
				default: set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			endcase
			if (phase == 1) begin
				// receiver stalls while the sender keeps pushing back to back
				hold_req        = 1'b1;
				send_quiet_left = 200;
			end
			phase_end = bytes_sent + PHASE_BYTES;
			while (bytes_sent < phase_end)
				random_frame();
			drain_records();
		end

		send_closing_case();
		drain_records();

		if (board.failures == 0 && board.pending_records.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
